// ===== src/ptm_pkg.sv =====
package ptm_pkg;

    // datapath widths
    localparam int XW           = 40;
    localparam int ZW           = 34;
    localparam int ATAN_ENTRIES = 24;
    localparam int EXP_BITS     = 16;
    localparam int SECH_BITS    = 32;
    localparam int QUOT_BITS    = 18;
    localparam int QUOT_STAGES  = 3;

    // exp(-1/4096) in q31
    localparam logic [31:0] EXP_T0 = 32'd2146959424;

    // angle constants in q30 radians
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;

    // atan(2^-i) in q30
    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // exp(-2^j/4096) in q31, by repeated rounded squaring
    function automatic logic [31:0] exp_step(input int j);
        logic [63:0] t;
        t = 64'(EXP_T0);
        for (int k = 0; k < j; k++) begin
            t = (t * t + 64'd1073741824) >> 31;
        end
        return t[31:0];
    endfunction

    // combined gain of rotation and vectoring in q30
    function automatic logic [31:0] gain_q30(input int n);
        logic [63:0] p;
        p = 64'd1073741824;
        for (int i = 0; i < n; i++) begin
            p = p + (p >> (2 * i));
        end
        return p[31:0];
    endfunction

endpackage

// ===== src/ptm_pair_if.sv =====
interface ptm_pair_if;
    logic               valid;
    logic               ready;
    logic [15:0]        lead_energy;
    logic signed [15:0] lead_pseudorapidity;
    logic signed [15:0] lead_azimuth;
    logic [15:0]        trail_energy;
    logic signed [15:0] trail_pseudorapidity;
    logic signed [15:0] trail_azimuth;

    modport source (
        output valid, lead_energy, lead_pseudorapidity, lead_azimuth,
               trail_energy, trail_pseudorapidity, trail_azimuth,
        input  ready
    );
    modport sink (
        input  valid, lead_energy, lead_pseudorapidity, lead_azimuth,
               trail_energy, trail_pseudorapidity, trail_azimuth,
        output ready
    );
endinterface

// ===== src/ptm_mom_if.sv =====
interface ptm_mom_if;
    logic        valid;
    logic        ready;
    logic [16:0] pair_momentum;

    modport source (output valid, pair_momentum, input ready);
    modport sink (input valid, pair_momentum, output ready);
endinterface

// ===== src/ptm_exp_cell.sv =====
module ptm_exp_cell import ptm_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_a,
    input  logic [31:0] i_u,
    output logic [15:0] o_a,
    output logic [31:0] o_u
);
    localparam logic [31:0] STEP = exp_step(BIT);

    logic [63:0] w_prod;
    logic [63:0] w_rnd;
    logic [15:0] r_a;
    logic [31:0] r_u;

    // multiply by this bit's factor when the bit is set
    assign w_prod = i_u * STEP;
    assign w_rnd  = w_prod + 64'd1073741824;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= i_a;
            r_u <= i_a[BIT] ? w_rnd[62:31] : i_u;
        end
    end

    assign o_a = r_a;
    assign o_u = r_u;
endmodule

// ===== src/ptm_div_cell.sv =====
module ptm_div_cell #(
    parameter int RW = 33,
    parameter int LW = 32,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [LW-1:0] i_low,
    input  logic [RW-1:0] i_den,
    input  logic [QW-1:0] i_q,
    output logic [RW-1:0] o_rem,
    output logic [LW-1:0] o_low,
    output logic [RW-1:0] o_den,
    output logic [QW-1:0] o_q
);
    logic [RW:0]   w_trial;
    logic [RW:0]   w_diff;
    logic          w_ge;
    logic [RW-1:0] r_rem;
    logic [LW-1:0] r_low;
    logic [RW-1:0] r_den;
    logic [QW-1:0] r_q;

    // one restoring step: bring down a bit, try the subtract
    assign w_trial = {i_rem, i_low[LW-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
            r_low <= {i_low[LW-2:0], 1'b0};
            r_den <= i_den;
            r_q   <= {i_q[QW-2:0], w_ge};
        end
    end

    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_den = r_den;
    assign o_q   = r_q;
endmodule

// ===== src/ptm_cordic_cell.sv =====
module ptm_cordic_cell import ptm_pkg::*; #(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);
    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic signed [ZW-1:0] w_atan;
    logic                 w_up;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    assign w_dx   = i_y >>> STAGE;
    assign w_dy   = i_x >>> STAGE;
    assign w_atan = ZW'(ATAN_Q30[STAGE]);

    // rotation steers by angle sign, vectoring drives y to zero
    assign w_up = VECTOR ? i_y[XW-1] : !i_z[ZW-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_up) begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - w_atan;
            end else begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + w_atan;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// ===== src/ptm_lane.sv =====
module ptm_lane import ptm_pkg::*; #(
    parameter int N = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [15:0]          i_energy,
    input  logic signed [15:0]   i_eta,
    input  logic signed [15:0]   i_phi,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y
);
    localparam int SIDE = EXP_BITS + 1 + SECH_BITS;

    logic [15:0]          w_exp_a [EXP_BITS];
    logic [31:0]          w_exp_u [EXP_BITS+1];
    logic [63:0]          w_sq;
    logic [63:0]          w_sq_rnd;
    logic [32:0]          w_den;
    logic [32:0]          w_drem [SECH_BITS];
    logic [31:0]          w_dlow [SECH_BITS];
    logic [32:0]          w_dden [SECH_BITS];
    logic [31:0]          w_dq   [SECH_BITS+1];
    logic [31:0]          r_side [SIDE];
    logic [31:0]          r_u;
    logic [31:0]          r_u2;
    logic [15:0]          w_e;
    logic signed [15:0]   w_phi;
    logic [47:0]          w_ept;
    logic signed [ZW-1:0] w_z;
    logic                 r_neg;
    logic signed [ZW-1:0] r_z;
    logic [36:0]          r_pt;
    logic signed [XW-1:0] w_pt_ext;
    logic signed [XW-1:0] w_rx [N+1];
    logic signed [XW-1:0] w_ry [N+1];
    logic signed [ZW-1:0] w_rz [N];

    // energy and azimuth ride alongside the sech chain
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= {i_energy, i_phi};
            for (int k = 1; k < SIDE; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // exp(-|eta|) as a product of one factor per set bit
    assign w_exp_a[0] = i_eta[15] ? (16'(~i_eta) + 16'd1) : 16'(i_eta);
    assign w_exp_u[0] = 32'h8000_0000;

    for (genvar j = 0; j < EXP_BITS; j++) begin : g_exp
        if (j < EXP_BITS - 1) begin : g_mid
            ptm_exp_cell #(.BIT(j)) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_a   (w_exp_a[j]), .i_u (w_exp_u[j]),
                .o_a   (w_exp_a[j+1]), .o_u (w_exp_u[j+1])
            );
        end else begin : g_end
            ptm_exp_cell #(.BIT(j)) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_a   (w_exp_a[j]), .i_u (w_exp_u[j]),
                .o_a   (), .o_u (w_exp_u[j+1])
            );
        end
    end

    // u squared
    assign w_sq     = w_exp_u[EXP_BITS] * w_exp_u[EXP_BITS];
    assign w_sq_rnd = w_sq + 64'd1073741824;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u  <= w_exp_u[EXP_BITS];
            r_u2 <= w_sq_rnd[62:31];
        end
    end

    // sech = 2u / (1 + u^2), one quotient bit per cell
    assign w_den   = 33'h0_8000_0000 + {1'b0, r_u2};
    assign w_dq[0] = '0;

    for (genvar k = 0; k < SECH_BITS; k++) begin : g_div
        if (k == 0) begin : g_first
            ptm_div_cell #(.RW(33), .LW(32), .QW(SECH_BITS)) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_rem ({1'b0, r_u}), .i_low (w_den[32:1]), .i_den (w_den),
                .i_q   (w_dq[k]),
                .o_rem (w_drem[k]), .o_low (w_dlow[k]), .o_den (w_dden[k]),
                .o_q   (w_dq[k+1])
            );
        end else if (k < SECH_BITS - 1) begin : g_mid
            ptm_div_cell #(.RW(33), .LW(32), .QW(SECH_BITS)) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_rem (w_drem[k-1]), .i_low (w_dlow[k-1]), .i_den (w_dden[k-1]),
                .i_q   (w_dq[k]),
                .o_rem (w_drem[k]), .o_low (w_dlow[k]), .o_den (w_dden[k]),
                .o_q   (w_dq[k+1])
            );
        end else begin : g_end
            ptm_div_cell #(.RW(33), .LW(32), .QW(SECH_BITS)) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_rem (w_drem[k-1]), .i_low (w_dlow[k-1]), .i_den (w_dden[k-1]),
                .i_q   (w_dq[k]),
                .o_rem (), .o_low (), .o_den (),
                .o_q   (w_dq[k+1])
            );
        end
    end
    assign w_drem[SECH_BITS-1] = '0;
    assign w_dlow[SECH_BITS-1] = '0;
    assign w_dden[SECH_BITS-1] = '0;

    // pt = energy * sech, azimuth folded into plus or minus pi/2
    assign w_e   = r_side[SIDE-1][31:16];
    assign w_phi = r_side[SIDE-1][15:0];
    assign w_ept = w_e * w_dq[SECH_BITS] + 48'd1024;
    assign w_z   = {w_phi[15], w_phi, 17'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt <= w_ept[47:11];
            priority if (w_z > HALF_PI_Q30) begin
                r_z   <= w_z - PI_Q30;
                r_neg <= 1'b1;
            end else if (w_z < -HALF_PI_Q30) begin
                r_z   <= w_z + PI_Q30;
                r_neg <= 1'b1;
            end else begin
                r_z   <= w_z;
                r_neg <= 1'b0;
            end
        end
    end

    // rotation chain
    assign w_pt_ext = {{(XW-37){1'b0}}, r_pt};
    assign w_rx[0]  = r_neg ? -w_pt_ext : w_pt_ext;
    assign w_ry[0]  = '0;

    for (genvar i = 0; i < N; i++) begin : g_rot
        if (i == 0) begin : g_first
            ptm_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_x (w_rx[i]), .i_y (w_ry[i]), .i_z (r_z),
                .o_x (w_rx[i+1]), .o_y (w_ry[i+1]), .o_z (w_rz[i])
            );
        end else if (i < N - 1) begin : g_mid
            ptm_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_x (w_rx[i]), .i_y (w_ry[i]), .i_z (w_rz[i-1]),
                .o_x (w_rx[i+1]), .o_y (w_ry[i+1]), .o_z (w_rz[i])
            );
        end else begin : g_end
            ptm_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_x (w_rx[i]), .i_y (w_ry[i]), .i_z (w_rz[i-1]),
                .o_x (w_rx[i+1]), .o_y (w_ry[i+1]), .o_z ()
            );
        end
    end
    assign w_rz[N-1] = '0;

    assign o_x = w_rx[N];
    assign o_y = w_ry[N];
endmodule

// ===== src/pair_transverse_momentum_top.sv =====
// channel  | direction | beat payload
// i_pair   | in        | lead/trail energy, pseudorapidity, azimuth
// o_mom    | out       | pair_momentum
//
// one pair beat per cycle while the spare entry is free; a result leaves once its beat has
// passed the sech bit chain (16 + 32 cells), two cordic chains and a reciprocal gain
// removal
// i_rst_n is synchronous, active low, and clears the valid bits only
// output register plus one spare entry; the pipeline holds only when both are full
module pair_transverse_momentum_top import ptm_pkg::*; #(
    parameter int ROTATION_STAGES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptm_pair_if.sink  i_pair,
    ptm_mom_if.source o_mom
);
    localparam int N    = (ROTATION_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : ROTATION_STAGES;
    localparam int LAT  = EXP_BITS + 1 + SECH_BITS + 1 + N + 1 + N + QUOT_STAGES;
    localparam logic [31:0] GAIN = gain_q30(N);
    localparam logic [QUOT_BITS-1:0] RECIP = QUOT_BITS'((64'd1 << 49) / 64'(GAIN));
    localparam logic [33:0] GAIN_X1 = {2'b00, GAIN};
    localparam logic [33:0] GAIN_X2 = {1'b0, GAIN, 1'b0};

    logic                 w_en;
    logic [LAT-1:0]       r_vld;
    logic signed [XW-1:0] w_xa;
    logic signed [XW-1:0] w_ya;
    logic signed [XW-1:0] w_xb;
    logic signed [XW-1:0] w_yb;
    logic signed [XW-1:0] w_sx;
    logic signed [XW-1:0] r_sx;
    logic signed [XW-1:0] r_sy;
    logic signed [XW-1:0] w_vx [N+1];
    logic signed [XW-1:0] w_vy [N];
    logic signed [ZW-1:0] w_vz [N];
    logic signed [XW-1:0] w_xc;
    logic [49:0]          w_num;
    logic [49:0]          w_qa_prod;
    logic [49:0]          r_num;
    logic [QUOT_BITS-1:0] r_qa;
    logic [49:0]          w_qg;
    logic [33:0]          r_grem;
    logic [QUOT_BITS-1:0] r_qb;
    logic [QUOT_BITS-1:0] r_quot;
    logic [16:0]          w_res;
    logic                 r_out_vld;
    logic [16:0]          r_out;
    logic                 r_hold_vld;
    logic [16:0]          r_hold;

    // pipeline moves whenever the spare entry is free
    assign w_en         = !r_hold_vld;
    assign i_pair.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_pair.valid};
        end
    end

    // one lane per particle
    ptm_lane #(.N(N)) u_lead (
        .i_clk (i_clk), .i_en (w_en),
        .i_energy (i_pair.lead_energy), .i_eta (i_pair.lead_pseudorapidity),
        .i_phi (i_pair.lead_azimuth),
        .o_x (w_xa), .o_y (w_ya)
    );

    ptm_lane #(.N(N)) u_trail (
        .i_clk (i_clk), .i_en (w_en),
        .i_energy (i_pair.trail_energy), .i_eta (i_pair.trail_pseudorapidity),
        .i_phi (i_pair.trail_azimuth),
        .o_x (w_xb), .o_y (w_yb)
    );

    // vector sum, x folded positive
    assign w_sx = w_xa + w_xb;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx <= w_sx[XW-1] ? -w_sx : w_sx;
            r_sy <= w_ya + w_yb;
        end
    end

    // vectoring chain for the length
    assign w_vx[0] = r_sx;
    assign w_vy[0] = r_sy;
    assign w_vz[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_vec
        if (i < N - 1) begin : g_mid
            ptm_cordic_cell #(.STAGE(i), .VECTOR(1'b1)) u_cell (
                .i_clk (i_clk), .i_en (w_en),
                .i_x (w_vx[i]), .i_y (w_vy[i]), .i_z (w_vz[i]),
                .o_x (w_vx[i+1]), .o_y (w_vy[i+1]), .o_z (w_vz[i+1])
            );
        end else begin : g_end
            ptm_cordic_cell #(.STAGE(i), .VECTOR(1'b1)) u_cell (
                .i_clk (i_clk), .i_en (w_en),
                .i_x (w_vx[i]), .i_y (w_vy[i]), .i_z (w_vz[i]),
                .o_x (w_vx[i+1]), .o_y (), .o_z ()
            );
        end
    end

    // gain removal: (x * 1024 + gain/2) / gain
    assign w_xc      = w_vx[N][XW-1] ? '0 : w_vx[N];
    assign w_num     = 50'({w_xc[XW-2:0], 10'd0}) + 50'(GAIN >> 1);

    // quotient estimate from the reciprocal, at most two short
    assign w_qa_prod = 50'(w_num[48:17]) * 50'(RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num <= w_num;
            r_qa  <= w_qa_prod[49:32];
        end
    end

    // remainder left by the estimate
    assign w_qg = 50'(r_qa) * 50'(GAIN);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_grem <= 34'(r_num - w_qg);
            r_qb   <= r_qa;
        end
    end

    // compare and step the estimate up
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            priority if (r_grem >= GAIN_X2) begin
                r_quot <= r_qb + QUOT_BITS'(2);
            end else if (r_grem >= GAIN_X1) begin
                r_quot <= r_qb + QUOT_BITS'(1);
            end else begin
                r_quot <= r_qb;
            end
        end
    end

    // saturate to the field
    assign w_res = r_quot[QUOT_BITS-1] ? 17'h1FFFF : r_quot[16:0];

    // output register with one spare entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else if (!r_out_vld || o_mom.ready) begin
            if (r_hold_vld) begin
                r_out_vld  <= 1'b1;
                r_hold_vld <= 1'b0;
            end else begin
                r_out_vld <= w_en && r_vld[LAT-1];
            end
        end else if (w_en && r_vld[LAT-1]) begin
            r_hold_vld <= 1'b1;
        end
    end

    // beat payloads
    always_ff @(posedge i_clk) begin
        if (!r_out_vld || o_mom.ready) begin
            r_out <= r_hold_vld ? r_hold : w_res;
        end else if (w_en) begin
            r_hold <= w_res;
        end
    end

    assign o_mom.valid         = r_out_vld;
    assign o_mom.pair_momentum = r_out;
endmodule
